// ===== design/pcsa_pkg.sv =====
// package for the per-channel sliding average unit
// shared widths, default sizes and the sequencer state type; no dependencies
`default_nettype none

package pcsa_pkg;

  // default sizes for the top level parameters
  localparam int unsigned CHANNELS_DEF   = 8;
  localparam int unsigned MAX_WINDOW_DEF = 64;

  // fixed field widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned WSIZE_W = 7;

  // window size after reset
  localparam logic [WSIZE_W-1:0] WSIZE_RST = WSIZE_W'(8);

  // item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_SLOT,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== design/pcsa_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module pcsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/pcsa_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module pcsa_div #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== design/per_channel_sliding_average_unit.sv =====
// per-channel sliding average: top level with item sequencer and state memories
// depends on pcsa_pkg, pcsa_ram and pcsa_div
//
//   channel   direction  handshake             payload
//   input     in         in_valid/in_ready     channel, voltage, end_of_record
//   output    out        out_valid/out_ready   average, channel_valid
//   config    in         window_size_we        window_size
//
// a valid-channel beat passes ST_REC, ST_SLOT, ST_DIV and ST_OUT from accept to output load,
// with SW = 16 + clog2(MAX_WINDOW) divider steps in ST_DIV; the next beat is taken back in ST_IDLE
// an out-of-range beat goes straight from accept to ST_OUT and loads the output from there
// one beat in flight; a stalled output only blocks once the following result is ready
// reset, a window size write and end_of_record clear the per-channel record valid bits
// the sample ram needs no clearing; only slots written since the last clear are read
`default_nettype none

module per_channel_sliding_average_unit #(
  parameter int unsigned CHANNELS   = pcsa_pkg::CHANNELS_DEF,
  parameter int unsigned MAX_WINDOW = pcsa_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         window_size_we_i,
  input  wire logic [pcsa_pkg::WSIZE_W-1:0] window_size_i,
  // sample beats
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [pcsa_pkg::CH_W-1:0]    channel_i,
  input  wire logic [pcsa_pkg::VOLT_W-1:0]  voltage_i,
  input  wire logic                         end_of_record_i,
  // result beats
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [pcsa_pkg::VOLT_W-1:0]  average_o,
  output logic                              channel_valid_o
);

  // channel index, head, fill count and sum widths
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned HW    = $clog2(MAX_WINDOW);
  localparam int unsigned FW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW    = pcsa_pkg::VOLT_W + $clog2(MAX_WINDOW);
  localparam int unsigned REC_W = SW + FW + HW;
  localparam int unsigned DEPTH = CHANNELS * MAX_WINDOW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned VW    = pcsa_pkg::VOLT_W;

  pcsa_pkg::state_e state_q, state_d;

  logic [pcsa_pkg::WSIZE_W-1:0] wsize_q;
  logic [FW-1:0]                win;

  // per-channel record valid bits, invalid reads as an empty window
  logic [CHANNELS-1:0] rec_vld_q, rec_vld_d;

  // captured beat
  logic [CW-1:0] ch_q, ch_d;
  logic [VW-1:0] volt_q, volt_d;
  logic          eor_q, eor_d;
  logic          ok_q, ok_d;

  // working copy of the channel record
  logic [SW-1:0] sum_q, sum_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [HW-1:0] head_q, head_d;
  logic          full_q, full_d;
  logic [AW-1:0] slot_q, slot_d;

  logic [VW-1:0] res_q, res_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] average_q, average_d;
  logic          chvalid_q, chvalid_d;

  // record ram
  logic             rec_we, rec_re;
  logic [CW-1:0]    rec_raddr;
  logic [REC_W-1:0] rec_wdata, rec_rdata, rec_rd;
  logic [SW-1:0]    rec_sum;
  logic [FW-1:0]    rec_fill;
  logic [HW-1:0]    rec_head;
  logic [HW-1:0]    head_eff;

  // sample ram
  logic          smp_we, smp_re;
  logic [AW-1:0] smp_raddr;
  logic [VW-1:0] smp_rdata;

  // update results
  logic [SW-1:0] sum_new;
  logic [FW-1:0] fill_new;
  logic [FW-1:0] head_p1;
  logic [HW-1:0] head_new;

  // divider
  logic          div_start, div_done;
  logic [SW-1:0] div_quo;

  logic in_acc;
  logic ch_in_range;

  // window size of 0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW
  always_comb begin
    if (wsize_q == '0) begin
      win = FW'(1);
    end else if (32'(wsize_q) > 32'(MAX_WINDOW)) begin
      win = FW'(MAX_WINDOW);
    end else begin
      win = FW'(wsize_q);
    end
  end

  assign in_acc      = in_valid_i && in_ready_o;
  assign ch_in_range = (32'(channel_i) < 32'(CHANNELS));

  // record fields as read, an invalid channel record is all zero
  assign rec_rd   = rec_vld_q[ch_q] ? rec_rdata : '0;
  assign rec_sum  = rec_rd[REC_W-1 -: SW];
  assign rec_fill = rec_rd[HW +: FW];
  assign rec_head = rec_rd[HW-1:0];
  assign head_eff = (FW'(rec_head) >= win) ? '0 : rec_head;

  // read-modify-write of the window; old sample only counts once the window is full
  assign sum_new  = sum_q + SW'(volt_q) - (full_q ? SW'(smp_rdata) : '0);
  assign fill_new = full_q ? fill_q : fill_q + FW'(1);
  assign head_p1  = FW'(head_q) + FW'(1);
  assign head_new = (head_p1 >= win) ? '0 : head_p1[HW-1:0];

  assign rec_wdata = {sum_new, fill_new, head_new};

  always_comb begin
    state_d     = state_q;
    rec_vld_d   = rec_vld_q;
    ch_d        = ch_q;
    volt_d      = volt_q;
    eor_d       = eor_q;
    ok_d        = ok_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    head_d      = head_q;
    full_d      = full_q;
    slot_d      = slot_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    average_d   = average_q;
    chvalid_d   = chvalid_q;
    rec_re      = 1'b0;
    rec_we      = 1'b0;
    rec_raddr   = channel_i[CW-1:0];
    smp_re      = 1'b0;
    smp_we      = 1'b0;
    smp_raddr   = AW'(32'(ch_q) * 32'(MAX_WINDOW) + 32'(head_eff));
    div_start   = 1'b0;
    in_ready_o  = 1'b0;

    // output register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pcsa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          ch_d   = channel_i[CW-1:0];
          volt_d = voltage_i;
          eor_d  = end_of_record_i;
          ok_d   = ch_in_range;
          if (ch_in_range) begin
            rec_re  = 1'b1;
            state_d = pcsa_pkg::ST_REC;
          end else begin
            // out-of-range channel touches no window, but a record end still clears
            res_d = '0;
            if (end_of_record_i) begin
              rec_vld_d = '0;
            end
            state_d = pcsa_pkg::ST_OUT;
          end
        end
      end
      pcsa_pkg::ST_REC: begin
        // record data is here; fetch the slot under the head
        sum_d   = rec_sum;
        fill_d  = rec_fill;
        head_d  = head_eff;
        full_d  = (rec_fill >= win);
        slot_d  = smp_raddr;
        smp_re  = 1'b1;
        state_d = pcsa_pkg::ST_SLOT;
      end
      pcsa_pkg::ST_SLOT: begin
        smp_we    = 1'b1;
        rec_we    = 1'b1;
        div_start = 1'b1;
        // record end clears as this beat's window update is written and its divide starts
        if (eor_q) begin
          rec_vld_d = '0;
        end else begin
          rec_vld_d[ch_q] = 1'b1;
        end
        state_d = pcsa_pkg::ST_DIV;
      end
      pcsa_pkg::ST_DIV: begin
        if (div_done) begin
          res_d   = div_quo[VW-1:0];
          state_d = pcsa_pkg::ST_OUT;
        end
      end
      pcsa_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          average_d   = res_q;
          chvalid_d   = ok_q;
          state_d     = pcsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcsa_pkg::ST_IDLE;
      end
    endcase

    // a window size write restarts every window
    if (window_size_we_i) begin
      rec_vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcsa_pkg::ST_IDLE;
      rec_vld_q   <= '0;
      out_valid_q <= 1'b0;
      wsize_q     <= pcsa_pkg::WSIZE_RST;
    end else begin
      state_q     <= state_d;
      rec_vld_q   <= rec_vld_d;
      out_valid_q <= out_valid_d;
      if (window_size_we_i) begin
        wsize_q <= window_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    volt_q    <= volt_d;
    eor_q     <= eor_d;
    ok_q      <= ok_d;
    sum_q     <= sum_d;
    fill_q    <= fill_d;
    head_q    <= head_d;
    full_q    <= full_d;
    slot_q    <= slot_d;
    res_q     <= res_d;
    average_q <= average_d;
    chvalid_q <= chvalid_d;
  end

  // per-channel sum, fill count and head
  pcsa_ram #(
    .WIDTH (REC_W),
    .DEPTH (CHANNELS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (ch_q),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  // circular sample windows, MAX_WINDOW slots per channel
  pcsa_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_smp_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (slot_q),
    .wdata_i (volt_q),
    .re_i    (smp_re),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  // average = sum / fill count
  pcsa_div #(
    .NUM_W (SW),
    .DEN_W (FW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_new),
    .den_i   (fill_new),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o     = out_valid_q;
  assign average_o       = average_q;
  assign channel_valid_o = chvalid_q;

`ifndef SYNTH
  // divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == pcsa_pkg::ST_DIV)
    else $error("divider done outside of divide wait");

  // an in-range beat goes on to the record read
  a_valid_ch_reads_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ch_in_range |=> state_q == pcsa_pkg::ST_REC)
    else $error("in-range beat did not read its record");

  // the divisor is never zero
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pcsa_pkg::ST_SLOT |-> fill_new != '0)
    else $error("zero fill count at divide start");

  // a pending result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pcsa_pkg::ST_OUT && out_valid_q && !out_ready_i
      |=> state_q == pcsa_pkg::ST_OUT)
    else $error("result loaded over a pending output beat");

  // after a record end every window is empty
  a_eor_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pcsa_pkg::ST_SLOT && eor_q |=> rec_vld_q == '0)
    else $error("record end left a window valid");
`endif

endmodule

`default_nettype wire
